// File: rtl/matrix_vector_transform4_defines.svh
// assertion macros for the matrix_vector_transform4 block
// needs clk and rst in the scope of each use; no other dependencies
`ifndef MATRIX_VECTOR_TRANSFORM4_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM4_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MVT4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvt4 check failed");

// next-cycle implication, disabled while reset is high
`define MVT4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvt4 check failed");

`endif

// File: rtl/mvt4_pkg.sv
// shared constants, types and codes for the 4x4 matrix-vector transform
// no dependencies
`timescale 1ns / 1ps

package mvt4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM       = 4;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 4;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int UPPER_W   = SUM_W - FRAC_BITS - VAL_W + 1;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = DIM * VAL_W;

  // bit offsets inside the input tdata
  localparam int IDX_LSB = 0;
  localparam int VAL_LSB = IDX_LSB + IDX_W;
  localparam int VEC_LSB = VAL_LSB + VAL_W;

  localparam logic signed [VAL_W-1:0] ONE_FIXED = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] SAT_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_XFORM = 1'b1
  } kind_t;

  typedef logic signed [VAL_W-1:0] fixed_t;
  typedef fixed_t vec4_t [DIM];

  // per-stage load enables shared by all lanes
  typedef struct packed {
    logic en_mul;
    logic en_pair;
    logic en_sum;
  } lane_ctrl_t;

endpackage

// File: rtl/mvt4_lane.sv
// one row lane: four products, pairwise sums, final sum with truncation and saturation
// depends on mvt4_pkg
`timescale 1ns / 1ps

module mvt4_lane (
  input  logic                clk,
  input  mvt4_pkg::lane_ctrl_t ctrl,
  input  mvt4_pkg::vec4_t     row,
  input  mvt4_pkg::vec4_t     vec,
  output mvt4_pkg::fixed_t    result,
  output logic                sat
);

  logic signed [mvt4_pkg::PROD_W-1:0]  prod [mvt4_pkg::DIM];
  logic signed [mvt4_pkg::PAIR_W-1:0]  pair_lo;
  logic signed [mvt4_pkg::PAIR_W-1:0]  pair_hi;
  logic signed [mvt4_pkg::SUM_W-1:0]   total;
  logic [mvt4_pkg::UPPER_W-1:0]        upper;
  logic                                sat_pos;
  logic                                sat_neg;
  mvt4_pkg::fixed_t                    result_next;

  // stage 1: one multiplier per column
  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int c = 0; c < mvt4_pkg::DIM; c++) begin
        prod[c] <= mvt4_pkg::PROD_W'(row[c]) * mvt4_pkg::PROD_W'(vec[c]);
      end
    end
  end

  // stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (ctrl.en_pair) begin
      pair_lo <= mvt4_pkg::PAIR_W'(prod[0]) + mvt4_pkg::PAIR_W'(prod[1]);
      pair_hi <= mvt4_pkg::PAIR_W'(prod[2]) + mvt4_pkg::PAIR_W'(prod[3]);
    end
  end

  // stage 3: exact sum, floor shift by dropping fraction bits, clip to 32 bits
  always_comb begin
    total       = mvt4_pkg::SUM_W'(pair_lo) + mvt4_pkg::SUM_W'(pair_hi);
    upper       = total[mvt4_pkg::SUM_W-1 : mvt4_pkg::FRAC_BITS + mvt4_pkg::VAL_W - 1];
    sat_pos     = !total[mvt4_pkg::SUM_W-1] && (|upper);
    sat_neg     = total[mvt4_pkg::SUM_W-1] && !(&upper);
    result_next = total[mvt4_pkg::FRAC_BITS + mvt4_pkg::VAL_W - 1 : mvt4_pkg::FRAC_BITS];
    if (sat_pos) begin
      result_next = mvt4_pkg::SAT_MAX;
    end else if (sat_neg) begin
      result_next = mvt4_pkg::SAT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_sum) begin
      result <= result_next;
      sat    <= sat_pos || sat_neg;
    end
  end

endmodule

// File: rtl/mvt4_merge.sv
// output register: gathers the four lane results and their clip flags into one item
// depends on mvt4_pkg
`timescale 1ns / 1ps

module mvt4_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mvt4_pkg::vec4_t                      lane_result,
  input  logic [mvt4_pkg::DIM-1:0]             lane_sat,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mvt4_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tuser
);

  logic [mvt4_pkg::OUT_DATA_W-1:0] data_next;

  assign in_ready = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    for (int r = 0; r < mvt4_pkg::DIM; r++) begin
      data_next[r*mvt4_pkg::VAL_W +: mvt4_pkg::VAL_W] = lane_result[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= |lane_sat;
    end
  end

endmodule

// File: rtl/matrix_vector_transform4.sv
// a transform item passes 3 lane stages (multiply, pairwise sum, final sum), then the output register
// throughput: one item per cycle while m_axis_tready takes the results; a load item gives no result
// the rate is set by the four row lanes, each with four 32x32 multipliers, all fully pipelined
// reset (rst, synchronous, active high) empties the pipeline and sets the matrix to identity
// top level of the 4x4 matrix-vector transform; depends on mvt4_pkg, mvt4_lane, mvt4_merge
// and the assertion macros in matrix_vector_transform4_defines.svh
`timescale 1ns / 1ps
`include "matrix_vector_transform4_defines.svh"

module matrix_vector_transform4 (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // from bit 0: entry_index[3:0], entry_value[35:4], vec_x[67:36], vec_y[99:68],
  // vec_z[131:100], vec_w[163:132], zero fill [167:164]
  input  logic [mvt4_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // kind: 0 loads one matrix entry, 1 transforms a vector
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // from bit 0: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [mvt4_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // saturated: set when any of the four components was clipped
  output logic                                 m_axis_tuser
);

  // matrix entries, row-major; each lane reads its own row at fixed places
  mvt4_pkg::vec4_t matrix [mvt4_pkg::DIM];

  logic                                s_fire;
  logic                                load_fire;
  logic                                vec_fire;
  logic [mvt4_pkg::IDX_W-1:0]          entry_index;
  mvt4_pkg::fixed_t                    entry_value;
  mvt4_pkg::vec4_t                     vec_in;

  // pipeline occupancy, one bit per lane stage
  logic                                v_mul;
  logic                                v_pair;
  logic                                v_sum;
  logic                                rdy_mul;
  logic                                rdy_pair;
  logic                                rdy_sum;
  logic                                out_ready;
  mvt4_pkg::lane_ctrl_t                ctrl;

  mvt4_pkg::vec4_t                     lane_result;
  logic [mvt4_pkg::DIM-1:0]            lane_sat;

  // item decode
  assign s_fire      = s_axis_tvalid && s_axis_tready;
  assign load_fire   = s_fire && (mvt4_pkg::kind_t'(s_axis_tuser) == mvt4_pkg::KIND_LOAD);
  assign vec_fire    = s_fire && (mvt4_pkg::kind_t'(s_axis_tuser) == mvt4_pkg::KIND_XFORM);
  assign entry_index = s_axis_tdata[mvt4_pkg::IDX_LSB +: mvt4_pkg::IDX_W];
  assign entry_value = s_axis_tdata[mvt4_pkg::VAL_LSB +: mvt4_pkg::VAL_W];

  always_comb begin
    for (int c = 0; c < mvt4_pkg::DIM; c++) begin
      vec_in[c] = s_axis_tdata[mvt4_pkg::VEC_LSB + c*mvt4_pkg::VAL_W +: mvt4_pkg::VAL_W];
    end
  end

  // a stage takes new work when it is empty or its contents move on; bubbles collapse
  assign rdy_sum       = !v_sum  || out_ready;
  assign rdy_pair      = !v_pair || rdy_sum;
  assign rdy_mul       = !v_mul  || rdy_pair;
  // no item is taken while reset is high
  assign s_axis_tready = rdy_mul && !rst;

  assign ctrl.en_mul  = vec_fire;
  assign ctrl.en_pair = rdy_pair && v_mul;
  assign ctrl.en_sum  = rdy_sum  && v_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul  <= 1'b0;
      v_pair <= 1'b0;
      v_sum  <= 1'b0;
    end else begin
      if (rdy_mul) begin
        v_mul <= vec_fire;
      end
      if (rdy_pair) begin
        v_pair <= v_mul;
      end
      if (rdy_sum) begin
        v_sum <= v_pair;
      end
    end
  end

  // matrix store: products of a vector already in flight are registered, so a load
  // right behind it cannot disturb it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mvt4_pkg::DIM; r++) begin
        for (int c = 0; c < mvt4_pkg::DIM; c++) begin
          matrix[r][c] <= (r == c) ? mvt4_pkg::ONE_FIXED : '0;
        end
      end
    end else if (load_fire) begin
      matrix[entry_index[3:2]][entry_index[1:0]] <= entry_value;
    end
  end

  // one lane per matrix row
  for (genvar r = 0; r < mvt4_pkg::DIM; r++) begin : g_lane
    mvt4_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .row    (matrix[r]),
      .vec    (vec_in),
      .result (lane_result[r]),
      .sat    (lane_sat[r])
    );
  end

  // merging stage and output register
  mvt4_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v_sum),
    .in_ready      (out_ready),
    .lane_result   (lane_result),
    .lane_sat      (lane_sat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // a transform item always enters the multiply stage
  `MVT4_ASSERT_NEXT(a_vec_enters, vec_fire, v_mul)
  // a load item never occupies the pipeline
  `MVT4_ASSERT_NEXT(a_load_no_slot, load_fire, !v_mul)
  // a result can only appear from a filled final lane stage
  `MVT4_ASSERT_NEXT(a_out_from_sum, !m_axis_tvalid && !v_sum, !m_axis_tvalid)
  // an empty multiply stage is always ready to take an item
  `MVT4_ASSERT_NOW(a_ready_empty, !v_mul, s_axis_tready)

endmodule
